FILE: design/mrkt_pkg.sv
`default_nettype none

package mrkt_pkg;

    // table depth default
    localparam int ENTRIES_DEF = 64;

    // field widths
    localparam int OP_W   = 2;
    localparam int ST_W   = 3;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = 48;
    localparam int ACC_W  = 16;
    localparam int CTX_W  = 32;
    localparam int NKEY_W = KEY_W + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [ST_W-1:0] ST_DENIED    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOKEY     = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd5;

    // input beat payload, last member in the lowest bits
    typedef struct packed {
        logic [ACC_W-1:0]  requested_access;
        logic [ADDR_W-1:0] access_length;
        logic [ADDR_W-1:0] address;
        logic [CTX_W-1:0]  context_tag;
        logic [ACC_W-1:0]  region_access;
        logic [ADDR_W-1:0] region_offset;
        logic [ADDR_W-1:0] region_length;
        logic [ADDR_W-1:0] region_base;
        logic [KEY_W-1:0]  key;
    } item_t;

    // result beat payload, last member in the lowest bits
    typedef struct packed {
        logic [ADDR_W-1:0] address_out;
        logic [CTX_W-1:0]  context_out;
        logic [KEY_W-1:0]  key_out;
    } result_t;

    localparam int IN_DATA_W  = $bits(item_t);
    localparam int OUT_DATA_W = $bits(result_t);

    // one table row
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] offset;
        logic [ACC_W-1:0]  access;
        logic [CTX_W-1:0]  ctx_tag;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic calc1;
        logic calc2;
        logic fin;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic skip;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/memory_region_key_table_core.sv
// channel   dir  handshake            payload
// cfg       in   cfg_we               cfg_wdata: mode
// s         in   s_tvalid / s_tready  s_tuser: operation; s_tdata: request fields
// m         out  m_tvalid / m_tready  m_tuser: status; m_tdata: key, context, address
//
// the table search reads one row per cycle from the single-port table memory and stops
// at a key match or after the last row
// an insert rejected on its arguments or on exhausted keys and an unknown operation skip the search
// after reset a clearing pass marks every row empty; s_tready stays low
// a finished result waits in the output register; the next item is accepted meanwhile,
// and its result holds in the last step until the output register is drained
`default_nettype none

module memory_region_key_table_core
#(
    parameter int ENTRIES = mrkt_pkg::ENTRIES_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_wdata,
    // request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // key, region_base, region_length, region_offset, region_access, context_tag,
    // address, access_length, requested_access
    input  wire logic [mrkt_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  wire logic [mrkt_pkg::OP_W-1:0]          s_tuser,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // key_out, context_out, address_out
    output logic [mrkt_pkg::OUT_DATA_W-1:0]         m_tdata,
    // status
    output logic [mrkt_pkg::ST_W-1:0]               m_tuser
);

    mrkt_pkg::cmd_t     cmd;
    mrkt_pkg::dp_stat_t stat;
    mrkt_pkg::item_t    in_item;
    mrkt_pkg::result_t  res_data;

    assign in_item = mrkt_pkg::item_t'(s_tdata);
    assign m_tdata = mrkt_pkg::OUT_DATA_W'(res_data);

    // sequencer
    mrkt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and checks
    mrkt_datapath
    #(
        .ENTRIES (ENTRIES)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_item    (in_item),
        .res_status (m_tuser),
        .res_data   (res_data)
    );

`ifndef SYNTHESIS
    // a result never appears in the cycle after a request beat is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result raised right after request beat");

    // a new result is only produced while requests are held off
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced while idle");

    // key_out is zero on every failed operation
    a_key_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != mrkt_pkg::ST_OK)) |->
            (m_tdata[mrkt_pkg::KEY_W-1:0] == '0))
        else $error("key_out set on failed operation");
`endif

endmodule

`default_nettype wire

FILE: design/mrkt_ctrl.sv
`default_nettype none

module mrkt_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire mrkt_pkg::dp_stat_t stat,
    output mrkt_pkg::cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CALC1,
        S_CALC2,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // output slot is free when empty or being drained
    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign s_tready  = (state_reg == S_IDLE);

    // sequencing and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.skip || stat.scan_done)
                begin
                    state_next = S_CALC1;
                end
            end
            S_CALC1:
            begin
                cmd.calc1  = 1'b1;
                state_next = S_CALC2;
            end
            S_CALC2:
            begin
                cmd.calc2  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.fin        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/mrkt_datapath.sv
`default_nettype none

module mrkt_datapath
#(
    parameter int ENTRIES = mrkt_pkg::ENTRIES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire mrkt_pkg::cmd_t                cmd,
    output mrkt_pkg::dp_stat_t                 stat,
    input  wire logic [mrkt_pkg::OP_W-1:0]     in_op,
    input  wire mrkt_pkg::item_t               in_item,
    output logic [mrkt_pkg::ST_W-1:0]          res_status,
    output mrkt_pkg::result_t                  res_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // configuration and key counter
    logic                             mode_reg;
    logic [mrkt_pkg::NKEY_W-1:0]      next_key_reg;

    // current item
    logic [mrkt_pkg::OP_W-1:0]        op_reg;
    mrkt_pkg::item_t                  item_reg;
    logic [mrkt_pkg::KEY_W-1:0]       newkey_reg;

    // table and scan
    mrkt_pkg::entry_t                 mem [ENTRIES];
    mrkt_pkg::entry_t                 rd_reg;
    logic [IW-1:0]                    rd_idx_reg;
    logic [IW-1:0]                    idx_reg;
    logic                             issue_done_reg;
    logic                             rd_live_reg;
    logic                             hit_reg;
    logic [IW-1:0]                    hit_idx_reg;
    mrkt_pkg::entry_t                 hit_entry_reg;
    logic                             free_found_reg;
    logic [IW-1:0]                    free_idx_reg;

    // check pipeline
    logic [mrkt_pkg::ADDR_W-1:0]      adj_addr_reg;
    logic [mrkt_pkg::ADDR_W:0]        end_reg;
    logic [mrkt_pkg::ADDR_W:0]        sum_reg;
    logic [mrkt_pkg::ADDR_W-1:0]      ins_off_reg;
    logic                             zero_reg;
    logic                             lo_ok_reg;
    logic                             acc_ok_reg;

    // output payload
    logic [mrkt_pkg::ST_W-1:0]        status_reg;
    mrkt_pkg::result_t                out_reg;

    logic                             issue;
    logic                             examine;
    logic                             match;
    logic                             take_free;
    logic                             bad_arg;
    logic                             exhausted;
    logic                             hi_ok;
    logic                             ins_commit;
    logic                             era_commit;
    logic [mrkt_pkg::ST_W-1:0]        status_next;
    mrkt_pkg::result_t                out_next;
    logic                             wr_en;
    logic [IW-1:0]                    wr_idx;
    mrkt_pkg::entry_t                 wr_word;

    // scan control: one read issued and one row examined per cycle
    assign issue     = cmd.scan && !issue_done_reg;
    assign examine   = cmd.scan && rd_live_reg;
    assign match     = examine && rd_reg.valid && (rd_reg.key == newkey_reg);
    assign take_free = examine && !rd_reg.valid && !free_found_reg;

    // insert argument checks ahead of the search
    assign bad_arg   = (item_reg.region_length == '0) || (item_reg.context_tag == '0);
    assign exhausted = !mode_reg && next_key_reg[mrkt_pkg::NKEY_W-1];

    // status to controller
    always_comb
    begin
        stat            = '0;
        stat.clear_last = cmd.clear && (idx_reg == LAST);
        stat.scan_done  = examine && (match || (rd_idx_reg == LAST));
        case (op_reg)
            mrkt_pkg::OP_INSERT: stat.skip = bad_arg || exhausted;
            mrkt_pkg::OP_LOOKUP: stat.skip = 1'b0;
            mrkt_pkg::OP_ERASE:  stat.skip = 1'b0;
            default:             stat.skip = 1'b1;
        endcase
    end

    // upper bound of the access against the region end
    assign hi_ok = (end_reg >= sum_reg);

    // final decision per operation
    always_comb
    begin
        status_next = mrkt_pkg::ST_INVALID;
        out_next    = '0;
        ins_commit  = 1'b0;
        era_commit  = 1'b0;
        case (op_reg)
            mrkt_pkg::OP_INSERT:
            begin
                if (bad_arg)
                begin
                    status_next = mrkt_pkg::ST_INVALID;
                end
                else if (exhausted)
                begin
                    status_next = mrkt_pkg::ST_EXHAUSTED;
                end
                else if (hit_reg)
                begin
                    status_next = mrkt_pkg::ST_INVALID;
                end
                else if (!free_found_reg)
                begin
                    status_next = mrkt_pkg::ST_FULL;
                end
                else
                begin
                    status_next      = mrkt_pkg::ST_OK;
                    out_next.key_out = newkey_reg;
                    ins_commit       = 1'b1;
                end
            end
            mrkt_pkg::OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    out_next.context_out = hit_entry_reg.ctx_tag;
                    out_next.address_out = adj_addr_reg;
                    if (zero_reg)
                    begin
                        status_next = mrkt_pkg::ST_INVALID;
                    end
                    else if (!acc_ok_reg)
                    begin
                        status_next = mrkt_pkg::ST_DENIED;
                    end
                    else if (lo_ok_reg && hi_ok)
                    begin
                        status_next = mrkt_pkg::ST_OK;
                    end
                    else
                    begin
                        status_next = mrkt_pkg::ST_DENIED;
                    end
                end
            end
            mrkt_pkg::OP_ERASE:
            begin
                if (hit_reg)
                begin
                    status_next = mrkt_pkg::ST_OK;
                    era_commit  = 1'b1;
                end
                else
                begin
                    status_next = mrkt_pkg::ST_NOKEY;
                end
            end
            default:
            begin
                status_next = mrkt_pkg::ST_INVALID;
            end
        endcase
    end

    // table write port: clearing pass, insert or erase
    always_comb
    begin
        wr_en   = cmd.clear || (cmd.fin && (ins_commit || era_commit));
        wr_idx  = cmd.clear ? idx_reg : (ins_commit ? free_idx_reg : hit_idx_reg);
        wr_word = '0;
        if (ins_commit)
        begin
            wr_word.valid   = 1'b1;
            wr_word.key     = newkey_reg;
            wr_word.base    = item_reg.region_base;
            wr_word.length  = item_reg.region_length;
            wr_word.offset  = ins_off_reg;
            wr_word.access  = item_reg.region_access;
            wr_word.ctx_tag = item_reg.context_tag;
        end
    end

    // table memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (issue)
        begin
            rd_reg     <= mem[idx_reg];
            rd_idx_reg <= idx_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            next_key_reg   <= '0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_live_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.fin && ins_commit && !mode_reg)
            begin
                next_key_reg <= next_key_reg + 1'b1;
            end
            if (cmd.load)
            begin
                idx_reg        <= '0;
                issue_done_reg <= 1'b0;
                rd_live_reg    <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.clear || issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (issue)
                begin
                    issue_done_reg <= (idx_reg == LAST);
                end
                if (cmd.scan)
                begin
                    rd_live_reg <= issue;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (take_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // item capture, hit capture, checks and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            item_reg   <= in_item;
            // only a basic insert searches for the counter key
            newkey_reg <= (mode_reg || (in_op != mrkt_pkg::OP_INSERT))
                          ? in_item.key : next_key_reg[mrkt_pkg::KEY_W-1:0];
        end
        if (match)
        begin
            hit_idx_reg   <= rd_idx_reg;
            hit_entry_reg <= rd_reg;
        end
        if (take_free)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        // offset add and region end
        if (cmd.calc1)
        begin
            adj_addr_reg <= mode_reg ? (item_reg.address + hit_entry_reg.offset)
                                     : item_reg.address;
            end_reg      <= {1'b0, hit_entry_reg.base} + {1'b0, hit_entry_reg.length};
            ins_off_reg  <= mode_reg ? (item_reg.region_base + item_reg.region_offset)
                                     : item_reg.region_base;
        end
        // access end, zero, lower bound and rights
        if (cmd.calc2)
        begin
            sum_reg    <= {1'b0, adj_addr_reg} + {1'b0, item_reg.access_length};
            zero_reg   <= (adj_addr_reg == '0);
            lo_ok_reg  <= (hit_entry_reg.base <= adj_addr_reg);
            acc_ok_reg <= ((item_reg.requested_access & ~hit_entry_reg.access) == '0);
        end
        if (cmd.fin)
        begin
            status_reg <= status_next;
            out_reg    <= out_next;
        end
    end

    assign res_status = status_reg;
    assign res_data   = out_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mrkt_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    // the operation field is two bits wide, so code 3 can reach the block
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] A_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0]  K_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [ST_W-1:0] status;
        result_t         data;
    } region_outcome_t;

    typedef struct {
        bit                mode;
        logic [OP_W-1:0]   op;
        item_t             req;
        region_outcome_t   want;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // key, region_base, region_length, region_offset, region_access, context_tag,
    // address, access_length, requested_access
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    // operation
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // key_out, context_out, address_out
    logic [OUT_DATA_W-1:0] m_tdata;
    // status
    logic [ST_W-1:0]       m_tuser;

    // predictor copy of the region table
    logic                  mr_valid [ENTRIES];
    logic [KEY_W-1:0]      mr_key   [ENTRIES];
    logic [ADDR_W-1:0]     mr_base  [ENTRIES];
    logic [ADDR_W-1:0]     mr_len   [ENTRIES];
    logic [ADDR_W-1:0]     mr_off   [ENTRIES];
    logic [ACC_W-1:0]      mr_acc   [ENTRIES];
    logic [CTX_W-1:0]      mr_ctx   [ENTRIES];
    logic [NKEY_W-1:0]     mr_next_key;
    logic                  mr_mode;

    region_outcome_t awaited_results[$];
    dir_row_t        directed_rows[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int insert_bias       = 80;
    int random_count      = 0;
    int fail_count        = 0;
    int quiet_cycles      = 0;
    int hold_left         = 0;
    bit hold_request      = 1'b0;

    memory_region_key_table_core #(
        .ENTRIES (ENTRIES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    // lowest valid slot holding a key, -1 if none
    function automatic int key_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (mr_valid[i] && mr_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!mr_valid[i])
                return i;
        end
        return -1;
    endfunction

    // expected outcome of one request beat, updating the table copy
    function automatic void predict_region_op(input logic [OP_W-1:0] op, input item_t it,
                                              output region_outcome_t r);
        int                idx;
        bit                ok;
        logic [KEY_W-1:0]  nk;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W:0]   span_end;
        logic [ADDR_W:0]   acc_end;
        r        = '0;
        r.status = ST_INVALID;
        case (op)
            OP_INSERT:
            begin
                nk = it.key;
                ok = 1'b1;
                if (it.region_length == '0 || it.context_tag == '0)
                    ok = 1'b0;
                else if (!mr_mode)
                begin
                    if (mr_next_key[KEY_W])
                    begin
                        ok       = 1'b0;
                        r.status = ST_EXHAUSTED;
                    end
                    else
                        nk = mr_next_key[KEY_W-1:0];
                end
                // duplicate key keeps the invalid status
                if (ok && key_slot(nk) >= 0)
                    ok = 1'b0;
                if (ok)
                begin
                    idx = free_slot();
                    if (idx < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        mr_valid[idx] = 1'b1;
                        mr_key[idx]   = nk;
                        mr_base[idx]  = it.region_base;
                        mr_len[idx]   = it.region_length;
                        mr_off[idx]   = mr_mode ? it.region_base + it.region_offset
                                                : it.region_base;
                        mr_acc[idx]   = it.region_access;
                        mr_ctx[idx]   = it.context_tag;
                        if (!mr_mode)
                            mr_next_key = mr_next_key + 1'b1;
                        r.status       = ST_OK;
                        r.data.key_out = nk;
                    end
                end
            end
            OP_LOOKUP:
            begin
                idx = key_slot(it.key);
                if (idx >= 0)
                begin
                    a        = mr_mode ? it.address + mr_off[idx] : it.address;
                    span_end = {1'b0, mr_base[idx]} + {1'b0, mr_len[idx]};
                    acc_end  = {1'b0, a} + {1'b0, it.access_length};
                    r.data.context_out = mr_ctx[idx];
                    r.data.address_out = a;
                    if (a == '0)
                        r.status = ST_INVALID;
                    else if ((it.requested_access & mr_acc[idx]) != it.requested_access)
                        r.status = ST_DENIED;
                    else if (mr_base[idx] <= a && span_end >= acc_end)
                        r.status = ST_OK;
                    else
                        r.status = ST_DENIED;
                end
            end
            OP_ERASE:
            begin
                idx = key_slot(it.key);
                if (idx < 0)
                    r.status = ST_NOKEY;
                else
                begin
                    mr_valid[idx] = 1'b0;
                    r.status      = ST_OK;
                end
            end
            default:
                r.status = ST_INVALID;
        endcase
    endfunction

    function automatic void add_row(input bit m, input logic [OP_W-1:0] op,
            input logic [KEY_W-1:0] k, input logic [ADDR_W-1:0] b, l, o,
            input logic [ACC_W-1:0] ac, input logic [CTX_W-1:0] cx,
            input logic [ADDR_W-1:0] ad, al, input logic [ACC_W-1:0] ra,
            input logic [ST_W-1:0] st, input logic [KEY_W-1:0] ko,
            input logic [CTX_W-1:0] co, input logic [ADDR_W-1:0] ao);
        dir_row_t row;
        row.mode                 = m;
        row.op                   = op;
        row.req.key              = k;
        row.req.region_base      = b;
        row.req.region_length    = l;
        row.req.region_offset    = o;
        row.req.region_access    = ac;
        row.req.context_tag      = cx;
        row.req.address          = ad;
        row.req.access_length    = al;
        row.req.requested_access = ra;
        row.want.status           = st;
        row.want.data.key_out     = ko;
        row.want.data.context_out = co;
        row.want.data.address_out = ao;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[ADDR_W-1:0];
    endfunction

    // offer one request beat, predict its result once accepted
    task automatic send_item(input logic [OP_W-1:0] op, input item_t req, input bit typed,
                             input region_outcome_t typed_want);
        region_outcome_t want;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = req;
        do
            @(posedge clk);
        while (!s_tready);
        predict_region_op(op, req, want);
        awaited_results.push_back(typed ? typed_want : want);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // mode write with nothing in flight
    task automatic configure(input bit m);
        drain_results();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
        mr_mode   = m;
    endtask

    // mostly well-formed requests aimed at live keys and inside their regions
    task automatic make_random_request(output logic [OP_W-1:0] op, output item_t it);
        int          live[$];
        int          pick;
        int          roll;
        logic [63:0] pos;
        logic [63:0] room;
        logic [63:0] r64;
        logic [15:0] r16;
        logic [ADDR_W-1:0] target;
        it.key              = $urandom();
        it.region_base      = rand48() >> ($urandom_range(1) * $urandom_range(47));
        it.region_length    = rand48() >> $urandom_range(47);
        if (it.region_length == '0)
            it.region_length = 1;
        it.region_offset    = rand48();
        it.region_access    = $urandom();
        it.context_tag      = $urandom();
        it.address          = rand48();
        it.access_length    = rand48() >> $urandom_range(47);
        it.requested_access = $urandom();
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (mr_valid[i])
                live.push_back(i);
        end
        pick = live.size() ? live[$urandom_range(live.size() - 1)] : -1;
        roll = $urandom_range(99);
        if (roll < 2)
            op = OP_UNUSED;
        else if (roll < 2 + insert_bias)
            op = OP_INSERT;
        else if (roll < 2 + insert_bias + (98 - insert_bias) / 3)
            op = OP_ERASE;
        else
            op = OP_LOOKUP;
        case (op)
            OP_INSERT:
            begin
                if ($urandom_range(19) == 0)
                    it.region_length = '0;
                if ($urandom_range(19) == 0)
                    it.context_tag = '0;
                // duplicates, and small keys the basic counter will run into
                roll = $urandom_range(9);
                if (roll < 3 && pick >= 0)
                    it.key = mr_key[pick];
                else if (roll < 5)
                    it.key = $urandom_range(7);
            end
            OP_ERASE:
            begin
                if (pick >= 0 && $urandom_range(9) < 8)
                    it.key = mr_key[pick];
            end
            OP_LOOKUP:
            begin
                if (pick >= 0 && $urandom_range(9) < 9)
                begin
                    it.key = mr_key[pick];
                    roll   = $urandom_range(9);
                    if (roll < 7)
                    begin
                        pos    = {16'h0, rand48()} % {16'h0, mr_len[pick]};
                        room   = {16'h0, mr_len[pick]} - pos;
                        target = mr_base[pick] + pos[ADDR_W-1:0];
                        r64    = {$urandom(), $urandom()};
                        r64    = ($urandom_range(3) == 0) ? room : r64 % (room + 1);
                        it.access_length = r64[ADDR_W-1:0];
                    end
                    else if (roll == 7)
                    begin
                        target           = mr_base[pick] - 1'b1;
                        it.access_length = $urandom_range(255);
                    end
                    else if (roll == 8)
                    begin
                        target           = mr_base[pick] + mr_len[pick];
                        it.access_length = $urandom_range(255);
                    end
                    else
                        target = '0;
                    it.address = mr_mode ? target - mr_off[pick] : target;
                    if ($urandom_range(9) < 7)
                    begin
                        r16 = $urandom();
                        it.requested_access = mr_acc[pick] & r16;
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic run_random_phase(input bit m, input int s_pct, input int r_pct,
                                    input int n, input bit with_hold);
        logic [OP_W-1:0] op;
        item_t           req;
        configure(m);
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        if (with_hold)
            hold_request = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            // alternate filling and emptying stretches so the table reaches full
            if (random_count % 100 == 0)
                insert_bias = ((random_count / 100) % 2 == 0) ? 80 : 15;
            random_count++;
            make_random_request(op, req);
            send_item(op, req, 1'b0, '0);
        end
    endtask

    // result side: ready pattern, long hold-off on request, and comparison
    initial
    begin
        region_outcome_t want;
        result_t         got;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= receiver_idle_pct);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no request waiting");
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (got.key_out !== want.data.key_out)
                    begin
                        $error("key_out: expected %h, got %h", want.data.key_out, got.key_out);
                        fail_count++;
                    end
                    if (got.context_out !== want.data.context_out)
                    begin
                        $error("context_out: expected %h, got %h",
                               want.data.context_out, got.context_out);
                        fail_count++;
                    end
                    if (got.address_out !== want.data.address_out)
                    begin
                        $error("address_out: expected %h, got %h",
                               want.data.address_out, got.address_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
            mr_valid[i] = 1'b0;
        mr_next_key = '0;
        mr_mode     = 1'b0;

        // empty table, rejected arguments, basic keys from the counter
        add_row(0, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_INVALID, 0, 0, 0);
        add_row(0, OP_ERASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NOKEY, 0, 0, 0);
        add_row(0, OP_INSERT, 0, 48'h1000, 0, 0, 16'hFFFF, 1, 0, 0, 0, ST_INVALID, 0, 0, 0);
        add_row(0, OP_INSERT, 0, 48'h1000, 1, 0, 16'hFFFF, 0, 0, 0, 0, ST_INVALID, 0, 0, 0);
        add_row(0, OP_INSERT, K_MAX, 48'h1000, 48'h100, A_MAX, 16'h0003, K_MAX, 0, 0, 0,
                ST_OK, 0, 0, 0);
        add_row(0, OP_INSERT, 0, A_MAX, A_MAX, 0, 16'hFFFF, 1, 0, 0, 0, ST_OK, 1, 0, 0);
        // lookups: exact fit, zero address, missing right, past the end, below the base
        add_row(0, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 48'h1000, 48'h100, 16'h0003,
                ST_OK, 0, K_MAX, 48'h1000);
        add_row(0, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 48'h10, 0, ST_INVALID, 0, K_MAX, 0);
        add_row(0, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 48'h1000, 48'h10, 16'h0004,
                ST_DENIED, 0, K_MAX, 48'h1000);
        add_row(0, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 48'h1001, 48'h100, 16'h0001,
                ST_DENIED, 0, K_MAX, 48'h1001);
        add_row(0, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 48'hFFF, 1, 0, ST_DENIED, 0, K_MAX, 48'hFFF);
        // bounds sums beyond 48 bits must not wrap
        add_row(0, OP_LOOKUP, 1, 0, 0, 0, 0, 0, A_MAX, A_MAX, 16'hFFFF, ST_OK, 0, 1, A_MAX);
        add_row(0, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 48'h1100, 0, 0, ST_OK, 0, K_MAX, 48'h1100);
        add_row(0, OP_UNUSED, K_MAX, A_MAX, A_MAX, A_MAX, 16'hFFFF, K_MAX, A_MAX, A_MAX,
                16'hFFFF, ST_INVALID, 0, 0, 0);
        add_row(0, OP_ERASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(0, OP_ERASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NOKEY, 0, 0, 0);
        add_row(0, OP_INSERT, 0, 48'h4000, 48'h40, 0, 16'h8000, 32'h8000_0000, 0, 0, 0,
                ST_OK, 2, 0, 0);
        // scalable mode: requested keys, duplicates, offset added and wrapping
        add_row(1, OP_INSERT, K_MAX, 48'h2000, 48'h1000, 48'h10, 16'h0001, 5, 0, 0, 0,
                ST_OK, K_MAX, 0, 0);
        add_row(1, OP_INSERT, K_MAX, 48'h5000, 48'h10, 0, 0, 6, 0, 0, 0, ST_INVALID, 0, 0, 0);
        add_row(1, OP_INSERT, 2, 48'h5000, 48'h10, 0, 0, 6, 0, 0, 0, ST_INVALID, 0, 0, 0);
        add_row(1, OP_LOOKUP, K_MAX, 0, 0, 0, 0, 0, 0, 48'h10, 16'h0001,
                ST_OK, 0, 5, 48'h2010);
        add_row(1, OP_LOOKUP, K_MAX, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_DFF0, 48'h10, 16'h0001,
                ST_INVALID, 0, 5, 0);
        add_row(1, OP_INSERT, 0, A_MAX, 48'h10, A_MAX, 0, 7, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(1, OP_LOOKUP, 1, 0, 0, 0, 0, 0, 1, 0, 0, ST_INVALID, 0, 1, 0);
        add_row(1, OP_LOOKUP, 0, 0, 0, 0, 0, 0, 1, 48'h10, 0, ST_OK, 0, 7, A_MAX);
        // keys exhausted needs 2^32 basic inserts and is left to the predictor

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct   = 35;
        receiver_idle_pct = 71;
        configure(1'b0);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != mr_mode)
                configure(directed_rows[i].mode);
            send_item(directed_rows[i].op, directed_rows[i].req, 1'b1, directed_rows[i].want);
        end

        run_random_phase(1'b1, 35, 71, 150, 1'b0);
        run_random_phase(1'b0, 71, 35, 150, 1'b0);
        run_random_phase(1'b1, 0, 0, 150, 1'b1);
        run_random_phase(1'b0, 0, 0, 100, 1'b0);

        drain_results();
        repeat (ENTRIES + 5) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/mrkt_pkg.sv
design/mrkt_ctrl.sv
design/mrkt_datapath.sv
design/memory_region_key_table_core.sv
tb/tb.sv
